>>> hw/rtl/fst_pkg.sv
package fst_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int ZONE_BITS_DEF  = 4;

    localparam int FINGER_W     = 32;
    localparam int POS_W        = 16;
    localparam int DELTA_W      = 17;
    localparam int ZONE_FIELD_W = 4;
    localparam int SLOT_IDX_W   = 3;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;

    // s_tdata: op, finger_id, pos_x, pos_y, hit_zone, query_zone
    localparam int S_FIELDS_W = OP_W + FINGER_W + 2 * POS_W + 2 * ZONE_FIELD_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // m_tdata: status, slot_index, slot_found, zone_pressed, delta_x, delta_y
    localparam int M_FIELDS_W = STATUS_W + SLOT_IDX_W + 2 + 2 * DELTA_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    typedef enum logic [OP_W-1:0] {
        OP_DOWN   = 2'd0,
        OP_MOTION = 2'd1,
        OP_UP     = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_UNKNOWN = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ALU_MATCH_FINGER,
        ALU_MATCH_ZONE,
        ALU_SUB_X,
        ALU_SUB_Y
    } alu_fn_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic set_act;
        logic clr_act;
    } store_ctl_t;

endpackage

>>> hw/rtl/fst_slot_store.sv
module fst_slot_store
    import fst_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int ZONE_BITS  = ZONE_BITS_DEF,
    parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  store_ctl_t            ctl,
    input  logic [IDX_W-1:0]      rd_idx,
    input  logic [IDX_W-1:0]      wr_idx,
    input  logic [FINGER_W-1:0]   wr_finger,
    input  logic [ZONE_BITS-1:0]  wr_zone,
    input  logic [POS_W-1:0]      wr_ox,
    input  logic [POS_W-1:0]      wr_oy,
    input  logic [POS_W-1:0]      wr_cx,
    input  logic [POS_W-1:0]      wr_cy,
    output logic [SLOT_COUNT-1:0] active,
    output logic [FINGER_W-1:0]   rd_finger,
    output logic [ZONE_BITS-1:0]  rd_zone,
    output logic [POS_W-1:0]      rd_ox,
    output logic [POS_W-1:0]      rd_oy,
    output logic [POS_W-1:0]      rd_cx,
    output logic [POS_W-1:0]      rd_cy
);

    localparam int ENT_W = FINGER_W + ZONE_BITS + 4 * POS_W;

    logic [ENT_W-1:0]      mem [SLOT_COUNT];
    logic [ENT_W-1:0]      rd_data_reg;
    logic [SLOT_COUNT-1:0] active_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_idx] <= {wr_finger, wr_zone, wr_ox, wr_oy, wr_cx, wr_cy};
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    // entry contents are only trusted while the slot is active
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
        end else if (ctl.set_act) begin
            active_reg[wr_idx] <= 1'b1;
        end else if (ctl.clr_act) begin
            active_reg[wr_idx] <= 1'b0;
        end
    end

    assign active = active_reg;
    assign {rd_finger, rd_zone, rd_ox, rd_oy, rd_cx, rd_cy} = rd_data_reg;

endmodule

>>> hw/rtl/fst_alu.sv
module fst_alu
    import fst_pkg::*;
#(
    parameter int ZONE_BITS = ZONE_BITS_DEF
) (
    input  alu_fn_t               fn,
    input  logic [FINGER_W-1:0]   req_finger,
    input  logic [ZONE_BITS-1:0]  req_zone,
    input  logic [FINGER_W-1:0]   ent_finger,
    input  logic [ZONE_BITS-1:0]  ent_zone,
    input  logic [POS_W-1:0]      ent_ox,
    input  logic [POS_W-1:0]      ent_oy,
    input  logic [POS_W-1:0]      ent_cx,
    input  logic [POS_W-1:0]      ent_cy,
    output logic                  eq,
    output logic [DELTA_W-1:0]    diff
);

    logic [FINGER_W-1:0] a_op;
    logic [FINGER_W-1:0] b_op;

    always_comb begin
        case (fn)
            ALU_MATCH_FINGER: begin
                a_op = req_finger;
                b_op = ent_finger;
            end
            ALU_MATCH_ZONE: begin
                a_op = FINGER_W'(req_zone);
                b_op = FINGER_W'(ent_zone);
            end
            ALU_SUB_X: begin
                a_op = FINGER_W'(ent_cx);
                b_op = FINGER_W'(ent_ox);
            end
            ALU_SUB_Y: begin
                a_op = FINGER_W'(ent_cy);
                b_op = FINGER_W'(ent_oy);
            end
            default: begin
                a_op = req_finger;
                b_op = ent_finger;
            end
        endcase
    end

    assign eq   = (a_op == b_op);
    assign diff = {1'b0, a_op[POS_W-1:0]} - {1'b0, b_op[POS_W-1:0]};

endmodule

>>> hw/rtl/touch_finger_slot_tracker_top.sv
// A transaction walks the slots from 0 up, one slot per cycle through the registered store
// read and shared ALU, until the first match or the last slot; a query with a holder then
// computes delta_x and delta_y. A new transaction is accepted only once the previous result
// is loaded into the output register; a stalled result holds input.
// Reset: aresetn is synchronous, active low; clears all slots to free and drops
// any pending result.
module touch_finger_slot_tracker_top
    import fst_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int ZONE_BITS  = ZONE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // op, finger_id, pos_x, pos_y, hit_zone, query_zone (lowest bit up)
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status, slot_index, slot_found, zone_pressed, delta_x, delta_y (lowest bit up)
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_SUB_X,
        S_SUB_Y,
        S_OUT
    } state_t;

    state_t state_reg, state_next;

    op_t                  op_reg, op_next;
    logic [FINGER_W-1:0]  fid_reg, fid_next;
    logic [POS_W-1:0]     x_reg, x_next;
    logic [POS_W-1:0]     y_reg, y_next;
    logic [ZONE_BITS-1:0] hz_reg, hz_next;
    logic [ZONE_BITS-1:0] qz_reg, qz_next;

    logic [IDX_W-1:0] rd_addr_reg, rd_addr_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             issue_on_reg, issue_on_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             hit_reg, hit_next;
    logic             free_found_reg, free_found_next;

    status_t          res_status_reg, res_status_next;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    logic             res_found_reg, res_found_next;
    logic             res_pressed_reg, res_pressed_next;
    logic [DELTA_W-1:0] res_dx_reg, res_dx_next;
    logic [DELTA_W-1:0] res_dy_reg, res_dy_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    store_ctl_t           st_ctl;
    logic [IDX_W-1:0]     wr_idx;
    logic [ZONE_BITS-1:0] wr_zone;
    logic [POS_W-1:0]     wr_ox, wr_oy;
    logic [SLOT_COUNT-1:0] active;
    logic [FINGER_W-1:0]  rd_finger;
    logic [ZONE_BITS-1:0] rd_zone;
    logic [POS_W-1:0]     rd_ox, rd_oy, rd_cx, rd_cy;

    alu_fn_t            alu_fn;
    logic               alu_eq;
    logic [DELTA_W-1:0] alu_diff;
    logic               scan_match;
    logic               rd_go;
    logic               keep_entry;

    fst_slot_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .ZONE_BITS  (ZONE_BITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (st_ctl),
        .rd_idx    (rd_addr_reg),
        .wr_idx    (wr_idx),
        .wr_finger (fid_reg),
        .wr_zone   (wr_zone),
        .wr_ox     (wr_ox),
        .wr_oy     (wr_oy),
        .wr_cx     (x_reg),
        .wr_cy     (y_reg),
        .active    (active),
        .rd_finger (rd_finger),
        .rd_zone   (rd_zone),
        .rd_ox     (rd_ox),
        .rd_oy     (rd_oy),
        .rd_cx     (rd_cx),
        .rd_cy     (rd_cy)
    );

    fst_alu #(
        .ZONE_BITS (ZONE_BITS)
    ) u_alu (
        .fn         (alu_fn),
        .req_finger (fid_reg),
        .req_zone   (qz_reg),
        .ent_finger (rd_finger),
        .ent_zone   (rd_zone),
        .ent_ox     (rd_ox),
        .ent_oy     (rd_oy),
        .ent_cx     (rd_cx),
        .ent_cy     (rd_cy),
        .eq         (alu_eq),
        .diff       (alu_diff)
    );

    always_comb begin
        case (state_reg)
            S_SUB_X: alu_fn = ALU_SUB_X;
            S_SUB_Y: alu_fn = ALU_SUB_Y;
            default: alu_fn = (op_reg == OP_QUERY) ? ALU_MATCH_ZONE : ALU_MATCH_FINGER;
        endcase
    end

    // a query for zone none never matches
    assign scan_match = cmp_vld_reg && active[cmp_idx_reg] && alu_eq &&
                        ((op_reg != OP_QUERY) || (qz_reg != '0));
    assign rd_go      = (state_reg == S_SCAN) && issue_on_reg && !scan_match;

    // motion on a tracked finger keeps its zone and origin
    assign keep_entry = hit_reg && (op_reg == OP_MOTION);
    assign wr_zone    = keep_entry ? rd_zone : hz_reg;
    assign wr_ox      = keep_entry ? rd_ox : x_reg;
    assign wr_oy      = keep_entry ? rd_oy : y_reg;
    assign wr_idx     = hit_reg ? hit_idx_reg : free_idx_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        fid_next         = fid_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        hz_next          = hz_reg;
        qz_next          = qz_reg;
        rd_addr_next     = rd_addr_reg;
        cmp_idx_next     = cmp_idx_reg;
        hit_idx_next     = hit_idx_reg;
        free_idx_next    = free_idx_reg;
        issue_on_next    = issue_on_reg;
        cmp_vld_next     = cmp_vld_reg;
        hit_next         = hit_reg;
        free_found_next  = free_found_reg;
        res_status_next  = res_status_reg;
        res_idx_next     = res_idx_reg;
        res_found_next   = res_found_reg;
        res_pressed_next = res_pressed_reg;
        res_dx_next      = res_dx_reg;
        res_dy_next      = res_dy_reg;
        m_tdata_next     = m_tdata_reg;
        m_tvalid_next    = m_tvalid_reg;
        st_ctl           = '0;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next         = op_t'(s_tdata[1:0]);
                    fid_next        = s_tdata[33:2];
                    x_next          = s_tdata[49:34];
                    y_next          = s_tdata[65:50];
                    hz_next         = ZONE_BITS'(s_tdata[69:66]);
                    qz_next         = ZONE_BITS'(s_tdata[73:70]);
                    rd_addr_next    = '0;
                    issue_on_next   = 1'b1;
                    cmp_vld_next    = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN: begin
                // read slot k while comparing slot k-1
                st_ctl.rd_en = rd_go;
                cmp_vld_next = rd_go;
                cmp_idx_next = rd_addr_reg;
                if (rd_go) begin
                    if (rd_addr_reg == LAST_IDX) begin
                        issue_on_next = 1'b0;
                    end else begin
                        rd_addr_next = rd_addr_reg + 1'b1;
                    end
                end
                if (cmp_vld_reg && !active[cmp_idx_reg] && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (scan_match) begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    state_next   = S_APPLY;
                end else if (cmp_vld_reg && (cmp_idx_reg == LAST_IDX)) begin
                    hit_next   = 1'b0;
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                res_status_next  = ST_DONE;
                res_idx_next     = '0;
                res_found_next   = 1'b0;
                res_pressed_next = 1'b0;
                res_dx_next      = '0;
                res_dy_next      = '0;
                state_next       = S_OUT;
                case (op_reg)
                    OP_DOWN, OP_MOTION: begin
                        if (hit_reg || free_found_reg) begin
                            st_ctl.wr_en   = 1'b1;
                            st_ctl.set_act = 1'b1;
                            res_idx_next   = wr_idx;
                            res_found_next = 1'b1;
                        end else begin
                            res_status_next = ST_FULL;
                        end
                    end
                    OP_UP: begin
                        if (hit_reg) begin
                            st_ctl.clr_act = 1'b1;
                            res_idx_next   = hit_idx_reg;
                            res_found_next = 1'b1;
                        end else begin
                            res_status_next = ST_UNKNOWN;
                        end
                    end
                    OP_QUERY: begin
                        if (hit_reg) begin
                            res_idx_next     = hit_idx_reg;
                            res_found_next   = 1'b1;
                            res_pressed_next = 1'b1;
                            state_next       = S_SUB_X;
                        end
                    end
                    default: begin
                        res_status_next = ST_DONE;
                    end
                endcase
            end
            S_SUB_X: begin
                res_dx_next = alu_diff;
                state_next  = S_SUB_Y;
            end
            S_SUB_Y: begin
                res_dy_next = alu_diff;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{M_PAD_W{1'b0}}, res_dy_reg, res_dx_reg,
                                     res_pressed_reg, res_found_reg,
                                     SLOT_IDX_W'(res_idx_reg), res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        fid_reg         <= fid_next;
        x_reg           <= x_next;
        y_reg           <= y_next;
        hz_reg          <= hz_next;
        qz_reg          <= qz_next;
        rd_addr_reg     <= rd_addr_next;
        cmp_idx_reg     <= cmp_idx_next;
        hit_idx_reg     <= hit_idx_next;
        free_idx_reg    <= free_idx_next;
        hit_reg         <= hit_next;
        res_status_reg  <= res_status_next;
        res_idx_reg     <= res_idx_next;
        res_found_reg   <= res_found_next;
        res_pressed_reg <= res_pressed_next;
        res_dx_reg      <= res_dx_next;
        res_dy_reg      <= res_dy_next;
        m_tdata_reg     <= m_tdata_next;
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            issue_on_reg   <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_on_reg   <= issue_on_next;
            cmp_vld_reg    <= cmp_vld_next;
            free_found_reg <= free_found_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

endmodule

>>> hw/rtl/fst_checker.sv
module fst_checker
    import fst_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic m_found;
    logic m_pressed;

    assign m_found   = m_tdata[5];
    assign m_pressed = m_tdata[6];

    // reset drops any pending result
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == ST_DONE) || (m_tdata[1:0] == ST_FULL) ||
                     (m_tdata[1:0] == ST_UNKNOWN))
        else $error("undefined status code");

    // no slot means index, pressed flag and deflections all zero
    a_no_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_found) |->
            (m_tdata[4:2] == '0) && !m_pressed && (m_tdata[40:7] == '0))
        else $error("fields set without a slot");

    a_pressed_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_pressed) |-> m_found && (m_tdata[1:0] == ST_DONE))
        else $error("zone pressed without a holding slot");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind touch_finger_slot_tracker_top fst_checker u_fst_checker (.*);
